@@ src/sct_pkg.sv @@
package sct_pkg;

  localparam int unsigned FifoDepthDefault = 64;
  localparam int unsigned SizeBitsDefault  = 16;

  localparam int unsigned CreditW   = 24;
  localparam int unsigned CountW    = 32;
  localparam logic [CreditW-1:0] CreditReset = CreditW'(256 * 1024);
  localparam logic [CreditW-1:0] CreditMax   = {CreditW{1'b1}};
  localparam logic [CountW-1:0]  CountMax    = {CountW{1'b1}};

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_ERROR = 3'd3,
    OP_SEND  = 3'd4,
    OP_DONE  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_OPEN  = 3'd1,
    ST_NOT_CONN  = 3'd2,
    ST_ABORTED   = 3'd3,
    ST_NO_CREDIT = 3'd4,
    ST_ZERO_LEN  = 3'd5,
    ST_FULL      = 3'd6,
    ST_UNDERFLOW = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    LS_UNINIT  = 3'd0,
    LS_OPENING = 3'd1,
    LS_OPEN    = 3'd2,
    LS_CLOSED  = 3'd3,
    LS_ERROR   = 3'd4
  } link_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] packet_bytes;
  } in_t;

  typedef struct packed {
    status_e             status;
    logic                ready_to_send;
    logic                close_signal;
    link_e               link_state;
    logic [CreditW-1:0]  credit_left;
    logic [6:0]          in_flight;
    logic [CountW-1:0]   longest_discard_run;
    logic [CountW-1:0]   discarded_packets;
    logic [CountW-1:0]   attempted_packets;
  } out_t;

endpackage

@@ src/sct_ram.sv @@
module sct_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/send_credit_throttle_unit.sv @@
// send credit throttle: byte credit gate for a connection's outgoing packets
//
// in channel (in_valid_i / in_ready_o / in_data_i) carries one event per
// transaction: init, open, close, error, send of a packet size, or send
// complete. out channel (out_valid_o / out_ready_i / out_data_o) returns
// exactly one result transaction per event, in order.
//
// the result of an event is registered: it is valid in the cycle after the
// event is accepted. throughput is one event per cycle while results are
// taken; the in-flight size fifo sits in a synchronous ram whose head entry
// is prefetched every cycle, with a bypass for a push to the entry being
// read, so back to back sends and completes never wait.
//
// when the receiver stalls, the result stays in the output register and
// in_ready_o drops until it is taken; no further event is accepted.
//
// reset: link uninitialised, credit 256 KiB, fifo empty, statistics zero.
// the ram is not cleared; only pushed entries are ever popped.
// a write on cfg_we_i loads the credit from cfg_wdata_i only when no
// packet is in flight; otherwise the write is ignored.
module send_credit_throttle_unit
  import sct_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault,
  parameter int unsigned SizeBits  = SizeBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [CreditW-1:0] cfg_wdata_i
);

  localparam int unsigned PtrW  = $clog2(FifoDepth);
  localparam int unsigned FillW = $clog2(FifoDepth + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(FifoDepth);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(FifoDepth - 1);

  // connection and credit state
  link_e              link_q, link_d;
  logic [CreditW-1:0] credit_q, credit_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic               retry_q, retry_d;

  // discard statistics
  logic [CountW-1:0]  run_q, run_d;
  logic [CountW-1:0]  peak_q, peak_d;
  logic [CountW-1:0]  discards_q, discards_d;
  logic [CountW-1:0]  attempts_q, attempts_d;

  // output register
  logic               out_valid_q;
  out_t               out_q;
  out_t               res;

  // fifo ram ports and head bypass
  logic                ram_we;
  logic [SizeBits-1:0] ram_rdata;
  logic                byp_q;
  logic [SizeBits-1:0] byp_data_q;
  logic [SizeBits-1:0] pop_size;

  logic                in_fire;
  logic [SizeBits-1:0] size;
  logic [CreditW-1:0]  size_c;
  logic [CountW:0]     run_sum;
  logic [CreditW:0]    credit_sum;
  logic [CreditW-1:0]  credit_ret;

  // the output register frees up when its transaction leaves
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // packet size taken modulo the stored size width
  assign size   = SizeBits'(in_data_i.packet_bytes);
  assign size_c = CreditW'(size);

  // the ram output holds the entry at rd_ptr_q; a push to that entry in
  // the previous cycle is not yet visible there, so take it from the bypass
  assign pop_size = byp_q ? byp_data_q : ram_rdata;

  assign run_sum    = {1'b0, run_q} + (CountW + 1)'(size);
  assign credit_sum = {1'b0, credit_q} + (CreditW + 1)'(pop_size);
  assign credit_ret = credit_sum[CreditW] ? CreditMax : credit_sum[CreditW-1:0];

  always_comb begin
    link_d     = link_q;
    credit_d   = credit_q;
    fill_d     = fill_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    retry_d    = retry_q;
    run_d      = run_q;
    peak_d     = peak_q;
    discards_d = discards_q;
    attempts_d = attempts_q;
    ram_we     = 1'b0;
    res        = '0;
    res.status = ST_OK;

    if (in_fire) begin
      case (in_data_i.op)
        OP_INIT: begin
          if (link_q == LS_UNINIT) begin
            link_d = LS_OPENING;
          end
        end
        OP_OPEN: begin
          link_d = LS_OPEN;
        end
        OP_CLOSE: begin
          link_d = LS_CLOSED;
        end
        OP_ERROR: begin
          // the abort is reported unless the link is already closed or errored
          res.close_signal = !(link_q inside {LS_CLOSED, LS_ERROR});
          link_d           = LS_ERROR;
        end
        OP_SEND: begin
          if (link_q inside {LS_UNINIT, LS_OPENING}) begin
            res.status = ST_NOT_OPEN;
          end else if (link_q == LS_CLOSED) begin
            res.status = ST_NOT_CONN;
          end else if (link_q != LS_OPEN) begin
            res.status = ST_ABORTED;
          end else if (size == '0) begin
            res.status = ST_ZERO_LEN;
          end else begin
            attempts_d = (attempts_q == CountMax) ? CountMax : attempts_q + 1'b1;
            if (size_c > credit_q) begin
              // refused for lack of credit: grow the run and track its peak
              res.status = ST_NO_CREDIT;
              retry_d    = 1'b1;
              run_d      = run_sum[CountW] ? CountMax : run_sum[CountW-1:0];
              discards_d = (discards_q == CountMax) ? CountMax : discards_q + 1'b1;
              if (run_d > peak_q) begin
                peak_d = run_d;
              end
            end else begin
              run_d = '0;
              if (fill_q == FillFull) begin
                res.status = ST_FULL;
                retry_d    = 1'b1;
              end else begin
                ram_we   = 1'b1;
                wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
                fill_d   = fill_q + 1'b1;
                credit_d = credit_q - size_c;
              end
            end
          end
        end
        OP_DONE: begin
          if (fill_q == '0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
            fill_d   = fill_q - 1'b1;
            credit_d = credit_ret;
            if (retry_q && credit_ret != '0) begin
              res.ready_to_send = 1'b1;
              retry_d           = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // new credit limit reloads the credit only with nothing in flight
    if (cfg_we_i && fill_q == '0) begin
      credit_d = cfg_wdata_i;
    end

    res.link_state          = link_d;
    res.credit_left         = credit_d;
    res.in_flight           = 7'(fill_d);
    res.longest_discard_run = peak_d;
    res.discarded_packets   = discards_d;
    res.attempted_packets   = attempts_d;
  end

  sct_ram #(
    .Width (SizeBits),
    .Depth (FifoDepth)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (size),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= LS_UNINIT;
      credit_q    <= CreditReset;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      retry_q     <= 1'b0;
      run_q       <= '0;
      peak_q      <= '0;
      discards_q  <= '0;
      attempts_q  <= '0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      link_q      <= link_d;
      credit_q    <= credit_d;
      fill_q      <= fill_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      retry_q     <= retry_d;
      run_q       <= run_d;
      peak_q      <= peak_d;
      discards_q  <= discards_d;
      attempts_q  <= attempts_d;
      // push landing on the entry the ram reads this cycle
      byp_q       <= ram_we && (wr_ptr_q == rd_ptr_d);
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    byp_data_q <= size;
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/sct_checker.sv @@
module sct_checker
  import sct_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // result valid in the cycle after an accepted event
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result one cycle after accepted event");

  // single output register: no event taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("event accepted while result stalled");

  // retry pulse comes only from a successful completion with credit left
  a_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ready_to_send |->
      out_data_o.status == ST_OK && out_data_o.credit_left != '0)
    else $error("ready_to_send without credit");

endmodule

bind send_credit_throttle_unit sct_checker u_sct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sct_pkg::*;

  // spare op codes that the block must ignore
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // receiver hold-off long enough to back the block up completely
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned PhaseItems    = 75;

  // credit and link predictor plus the store of expected result transactions
  class credit_scoreboard;
    logic [CreditW-1:0] credit;
    link_e              link;
    logic [15:0]        in_flight_sizes[$];
    bit                 retry_armed;
    logic [CountW-1:0]  drop_run;
    logic [CountW-1:0]  drop_run_peak;
    logic [CountW-1:0]  drop_count;
    logic [CountW-1:0]  try_count;
    out_t               expected_q[$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        report_cap;

    function new();
      credit        = CreditReset;
      link          = LS_UNINIT;
      retry_armed   = 1'b0;
      drop_run      = '0;
      drop_run_peak = '0;
      drop_count    = '0;
      try_count     = '0;
      mismatches    = 0;
      results_seen  = 0;
      report_cap    = 60;
    endfunction

    function logic [CountW-1:0] saturating_add(input logic [CountW-1:0] a,
                                               input logic [CountW-1:0] b);
      logic [CountW:0] total;
      total = a + b;
      return total[CountW] ? CountMax : total[CountW-1:0];
    endfunction

    function void apply_limit(input logic [CreditW-1:0] value);
      if (in_flight_sizes.size() == 0) credit = value;
    endfunction

    function status_e try_send(input logic [15:0] size);
      if (link == LS_UNINIT || link == LS_OPENING) return ST_NOT_OPEN;
      if (link == LS_CLOSED) return ST_NOT_CONN;
      if (link != LS_OPEN) return ST_ABORTED;
      if (size == 0) return ST_ZERO_LEN;
      try_count = saturating_add(try_count, 1);
      if (size > credit) begin
        retry_armed = 1'b1;
        drop_run    = saturating_add(drop_run, size);
        drop_count  = saturating_add(drop_count, 1);
        if (drop_run > drop_run_peak) drop_run_peak = drop_run;
        return ST_NO_CREDIT;
      end
      drop_run = '0;
      if (in_flight_sizes.size() >= FifoDepthDefault) begin
        retry_armed = 1'b1;
        return ST_FULL;
      end
      in_flight_sizes = {in_flight_sizes, size};
      credit = credit - size;
      return ST_OK;
    endfunction

    function void note_event(input in_t ev);
      out_t            want;
      logic [CreditW:0] sum;
      logic [15:0]     oldest;
      want        = '0;
      want.status = ST_OK;
      case (ev.op)
        OP_INIT:  if (link == LS_UNINIT) link = LS_OPENING;
        OP_OPEN:  link = LS_OPEN;
        OP_CLOSE: link = LS_CLOSED;
        OP_ERROR: begin
          want.close_signal = (link != LS_CLOSED) && (link != LS_ERROR);
          link = LS_ERROR;
        end
        OP_SEND:  want.status = try_send(ev.packet_bytes);
        OP_DONE: begin
          if (in_flight_sizes.size() == 0) begin
            want.status = ST_UNDERFLOW;
          end else begin
            oldest = in_flight_sizes[0];
            in_flight_sizes.delete(0);
            sum    = credit + oldest;
            credit = sum[CreditW] ? CreditMax : sum[CreditW-1:0];
            if (retry_armed && credit != 0) begin
              want.ready_to_send = 1'b1;
              retry_armed        = 1'b0;
            end
          end
        end
        default: ;
      endcase
      want.link_state          = link;
      want.credit_left         = credit;
      want.in_flight           = 7'(in_flight_sizes.size());
      want.longest_discard_run = drop_run_peak;
      want.discarded_packets   = drop_count;
      want.attempted_packets   = try_count;
      expected_q = {expected_q, want};
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      if (mismatches < report_cap) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task compare_field(input string field, input logic [CountW-1:0] got,
                       input logic [CountW-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_seen, field, got, want));
    endtask

    task check_result(input out_t got);
      out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("status", got.status, want.status);
      compare_field("ready_to_send", got.ready_to_send, want.ready_to_send);
      compare_field("close_signal", got.close_signal, want.close_signal);
      compare_field("link_state", got.link_state, want.link_state);
      compare_field("credit_left", got.credit_left, want.credit_left);
      compare_field("in_flight", got.in_flight, want.in_flight);
      compare_field("longest_discard_run", got.longest_discard_run,
                    want.longest_discard_run);
      compare_field("discarded_packets", got.discarded_packets,
                    want.discarded_packets);
      compare_field("attempted_packets", got.attempted_packets,
                    want.attempted_packets);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               cfg_we_i;
  logic [CreditW-1:0] cfg_wdata_i;

  // idling switches shared between the stimulus and the receiver
  bit send_gaps    = 1'b1;
  bit recv_gaps    = 1'b1;
  bit hold_off_req = 1'b0;

  credit_scoreboard sb;

  send_credit_throttle_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // one monitor for both channels: an event is always noted before any
  // result seen at the same edge is checked, whatever the process order
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_event(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver: random back-pressure, plus one long hold-off on request,
  // counted here so the sender keeps offering throughout
  initial begin : receiver
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_ready_i <= !(recv_gaps && $urandom_range(99) < 27);
      @(posedge clk_i);
    end
  end

  function automatic in_t mk_event(input logic [2:0] op, input logic [15:0] bytes);
    in_t ev;
    ev.op           = op;
    ev.packet_bytes = bytes;
    return ev;
  endfunction

  // offer one transaction; valid is only lowered during an idle gap, so it
  // never gets two updates in the same step
  task automatic offer_event(input in_t ev);
    while (send_gaps && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CreditW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.apply_limit(value);
    cfg_we_i    <= 1'b0;
  endtask

  // walk the link through every state and hit each corner of the credit rules
  task automatic run_directed();
    offer_event(mk_event(OP_SEND, 16'd100));      // send before init
    offer_event(mk_event(OP_DONE, 16'd0));        // completion with nothing in flight
    offer_event(mk_event(OP_INIT, 16'd0));
    offer_event(mk_event(OP_INIT, 16'hFFFF));     // init ignored once opening
    offer_event(mk_event(OP_SEND, 16'd1));        // still opening
    offer_event(mk_event(OP_OPEN, 16'd0));
    offer_event(mk_event(OP_SEND, 16'd0));        // zero length
    repeat (4) offer_event(mk_event(OP_SEND, 16'hFFFF)); // leaves 4 bytes of credit
    offer_event(mk_event(OP_SEND, 16'd5));        // just over the credit
    offer_event(mk_event(OP_SEND, 16'hFFFF));     // discard run keeps growing
    offer_event(mk_event(OP_SEND, 16'd4));        // exact fit, run clears, credit 0
    offer_event(mk_event(OP_DONE, 16'd0));        // blocked sender gets its retry pulse
    offer_event(mk_event(OpSpareLo, 16'h5A5A));
    offer_event(mk_event(OpSpareHi, 16'hA5A5));
    offer_event(mk_event(OP_CLOSE, 16'd0));
    offer_event(mk_event(OP_SEND, 16'd7));        // closed
    offer_event(mk_event(OP_ERROR, 16'd0));       // error after close, no close pulse
    offer_event(mk_event(OP_SEND, 16'd7));        // aborted
    offer_event(mk_event(OP_OPEN, 16'd0));
    offer_event(mk_event(OP_ERROR, 16'd0));       // error on an open link pulses
    offer_event(mk_event(OP_INIT, 16'd0));        // ignored outside uninitialised
    offer_event(mk_event(OP_OPEN, 16'd0));
  endtask

  // mostly runs of sends and completions on an open link, with the odd
  // connection change and some raw noise
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    int unsigned send_pct;
    logic [15:0] size;
    in_t         ev;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // connection event, usually followed by a reopen
        ev = mk_event(3'($urandom_range(OP_ERROR, OP_INIT)), 16'($urandom));
        offer_event(ev);
        sent++;
        if ($urandom_range(99) < 75) begin
          offer_event(mk_event(OP_OPEN, 16'($urandom)));
          sent++;
        end
      end else if (pick < 13) begin
        offer_event(mk_event(3'($urandom), 16'($urandom)));
        sent++;
      end else begin
        // long bursts now and then so the in-flight fifo fills right up
        burst    = ($urandom_range(9) == 0) ? $urandom_range(80, 40)
                                            : $urandom_range(16, 1);
        send_pct = $urandom_range(95, 20);
        repeat (burst) begin
          if ($urandom_range(99) < send_pct) begin
            pick = $urandom_range(99);
            if (pick < 55)      size = 16'($urandom_range(255, 1));
            else if (pick < 75) size = 16'($urandom);
            else if (pick < 85) size = ($urandom_range(1) != 0) ? 16'hFFFF : 16'd0;
            else if (pick < 93) size = 16'($urandom_range(4095, 1));
            // aim at the remaining credit for exact and near fits
            else size = 16'(sb.credit + 24'($urandom_range(2)) - 24'd1);
            offer_event(mk_event(OP_SEND, size));
          end else begin
            offer_event(mk_event(OP_DONE, 16'($urandom)));
          end
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    sb          = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // one phase per credit limit, the limit written with the block idle;
    // a phase that ends with packets in flight leaves the credit untouched
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0:       write_limit(CreditMax);
        1:       write_limit(24'd1);
        2:       write_limit(CreditReset);
        3:       write_limit(24'($urandom_range(24'hFFFFFF, 1)));
        4:       write_limit(24'd300);
        default: write_limit(24'($urandom_range(200000, 1000)));
      endcase
      // a stretch without any idling on either side
      send_gaps = (phase != 2);
      recv_gaps = (phase != 2);
      // stall the receiver so the block backs up and drops in_ready_o
      if (phase == 3) hold_off_req = 1'b1;
      run_random(PhaseItems);
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
src/sct_pkg.sv
src/sct_ram.sv
src/send_credit_throttle_unit.sv
src/sct_checker.sv
tb/sv/testbench.sv
